FILE: hdl/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

  // Branch taken by the conversion
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  // Matrix element and quaternion part width
  localparam int ElemW    = 16;
  // Magnitude of a sum or difference of two elements
  localparam int MagW     = 17;
  // Quotient bits resolved by the divider
  localparam int QuoW     = 16;
  // Components produced by division (all but the main one)
  localparam int NumLanes = 3;
  // Width of one input matrix on the bus
  localparam int MatW     = 9 * ElemW;

endpackage

FILE: hdl/rmq_front.sv
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 18
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [MatW-1:0]                mat_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [RW-1:0]                  rad_o,
  output branch_e                        br_o,
  output logic [NumLanes-1:0]            neg_o,
  output logic [NumLanes-1:0][MagW-1:0]  mag_o
);

  localparam int XW = RW + 1;

  logic signed [ElemW-1:0] m [9];
  logic signed [XW-1:0]    one_c, tr, rad_s, m00x, m11x, m22x;
  logic signed [MagW-1:0]  dif [NumLanes];
  branch_e                 br;

  logic                          v_q;
  logic [RW-1:0]                 rad_q, rad_d;
  branch_e                       br_q;
  logic [NumLanes-1:0]           neg_q, neg_d;
  logic [NumLanes-1:0][MagW-1:0] mag_q, mag_d;
  logic                          adv;

  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign m[i] = mat_i[ElemW*i +: ElemW];
  end

  // Branch choice, radicand and the three off-diagonal terms
  always_comb begin
    one_c = XW'(1) <<< FRAC_BITS;
    m00x  = XW'(m[0]);
    m11x  = XW'(m[4]);
    m22x  = XW'(m[8]);
    tr    = m00x + m11x + m22x;
    if (tr >= 0) begin
      br = BR_TRACE;
    end else if (m[4] > m[0]) begin
      br = (m[8] > m[4]) ? BR_Z : BR_Y;
    end else begin
      br = (m[8] > m[0]) ? BR_Z : BR_X;
    end
    case (br)
      BR_TRACE: begin
        rad_s  = tr + one_c;
        dif[0] = MagW'(m[7]) - MagW'(m[5]);
        dif[1] = MagW'(m[2]) - MagW'(m[6]);
        dif[2] = MagW'(m[3]) - MagW'(m[1]);
      end
      BR_X: begin
        rad_s  = m00x - (m11x + m22x) + one_c;
        dif[0] = MagW'(m[7]) - MagW'(m[5]);
        dif[1] = MagW'(m[1]) + MagW'(m[3]);
        dif[2] = MagW'(m[6]) + MagW'(m[2]);
      end
      BR_Y: begin
        rad_s  = m11x - (m22x + m00x) + one_c;
        dif[0] = MagW'(m[2]) - MagW'(m[6]);
        dif[1] = MagW'(m[1]) + MagW'(m[3]);
        dif[2] = MagW'(m[5]) + MagW'(m[7]);
      end
      default: begin
        rad_s  = m22x - (m00x + m11x) + one_c;
        dif[0] = MagW'(m[3]) - MagW'(m[1]);
        dif[1] = MagW'(m[6]) + MagW'(m[2]);
        dif[2] = MagW'(m[5]) + MagW'(m[7]);
      end
    endcase
    // clamp radicand to one LSB
    if (rad_s < XW'(1)) begin
      rad_d = RW'(1);
    end else begin
      rad_d = rad_s[RW-1:0];
    end
    for (int l = 0; l < NumLanes; l++) begin
      neg_d[l] = dif[l][MagW-1];
      mag_d[l] = neg_d[l] ? MagW'(-dif[l]) : MagW'(dif[l]);
    end
  end

  assign adv     = !v_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      rad_q <= rad_d;
      br_q  <= br;
      neg_q <= neg_d;
      mag_q <= mag_d;
    end
  end

  assign valid_o = v_q;
  assign rad_o   = rad_q;
  assign br_o    = br_q;
  assign neg_o   = neg_q;
  assign mag_o   = mag_q;

endmodule

FILE: hdl/rmq_sqrt.sv
`timescale 1ns / 1ps

// Integer square root, one result bit per stage
module rmq_sqrt #(
  parameter int NW     = 32,
  parameter int SW     = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [NW-1:0]     n_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [SW-1:0]     s_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [SW-1:0]     v_q;
  logic [SW:0]       adv;
  logic [NW-1:0]     rem_q  [SW];
  logic [NW-1:0]     res_q  [SW];
  logic [SIDE_W-1:0] side_q [SW];

  assign adv[SW] = ready_i;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [NW-1:0]     rem_in, res_in, rem_d, res_d, bitc;
    logic [NW:0]       trial;
    logic [SIDE_W-1:0] side_in;
    logic              v_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = n_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign adv[k] = !v_q[k] || adv[k+1];

    // Trial subtract of res + bit
    always_comb begin
      bitc  = NW'(1) << (2 * (SW - 1 - k));
      trial = {1'b0, res_in} + {1'b0, bitc};
      ge    = {1'b0, rem_in} >= trial;
      rem_d = ge ? (rem_in - trial[NW-1:0]) : rem_in;
      res_d = ge ? ((res_in >> 1) + bitc) : (res_in >> 1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && v_in) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[SW-1];
  assign s_o     = res_q[SW-1][SW-1:0];
  assign side_o  = side_q[SW-1];

endmodule

FILE: hdl/rmq_div.sv
`timescale 1ns / 1ps

// Three-lane restoring divider: q = floor(((mag << F) + s) / (2s))
module rmq_div import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int SW        = 16,
  parameter int SIDE_W    = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [SW-1:0]                  s_i,
  input  logic [NumLanes-1:0][MagW-1:0]  mag_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [SW-1:0]                  s_o,
  output logic [NumLanes-1:0][QuoW-1:0]  quo_o,
  output logic [NumLanes-1:0]            ovf_o,
  output logic [SIDE_W-1:0]              side_o
);

  localparam int NUMW = MagW + FRAC_BITS + 1;
  localparam int DW   = SW + 1;
  localparam int CW   = ((NUMW > DW + QuoW) ? NUMW : (DW + QuoW)) + 1;
  // numerator stage, overflow stage, then one stage per quotient bit
  localparam int NS   = QuoW + 2;

  logic [NS-1:0]                 v_q;
  logic [NS:0]                   adv;
  logic [NumLanes-1:0][NUMW-1:0] rem_q  [NS];
  logic [NumLanes-1:0][QuoW-1:0] quo_q  [NS];
  logic [NumLanes-1:0]           ovf_q  [NS];
  logic [DW-1:0]                 d_q    [NS];
  logic [SIDE_W-1:0]             side_q [NS];

  assign adv[NS] = ready_i;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [NumLanes-1:0][NUMW-1:0] rem_in, rem_d;
    logic [NumLanes-1:0][QuoW-1:0] quo_in, quo_d;
    logic [NumLanes-1:0]           ovf_in, ovf_d;
    logic [DW-1:0]                 d_in, d_d;
    logic [SIDE_W-1:0]             side_in;
    logic                          v_in;
    logic [CW-1:0]                 t;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign ovf_in  = '0;
      assign d_in    = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign ovf_in  = ovf_q[j-1];
      assign d_in    = d_q[j-1];
      assign side_in = side_q[j-1];
      assign v_in    = v_q[j-1];
    end

    assign adv[j] = !v_q[j] || adv[j+1];

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      ovf_d = ovf_in;
      d_d   = d_in;
      t     = '0;
      if (j == 0) begin
        // numerator and divisor
        d_d = {s_i, 1'b0};
        for (int l = 0; l < NumLanes; l++) begin
          rem_d[l] = ({1'b0, mag_i[l], {FRAC_BITS{1'b0}}}) + NUMW'(s_i);
        end
      end else if (j == 1) begin
        // quotient beyond the resolved bits
        t = CW'(d_in) << QuoW;
        for (int l = 0; l < NumLanes; l++) begin
          ovf_d[l] = CW'(rem_in[l]) >= t;
        end
      end else begin
        t = CW'(d_in) << (QuoW - 1 - (j - 2));
        for (int l = 0; l < NumLanes; l++) begin
          if (CW'(rem_in[l]) >= t) begin
            rem_d[l] = rem_in[l] - t[NUMW-1:0];
            quo_d[l] = quo_in[l] | (QuoW'(1) << (QuoW - 1 - (j - 2)));
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (adv[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[j] && v_in) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        ovf_q[j]  <= ovf_d;
        d_q[j]    <= d_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];
  assign s_o     = d_q[NS-1][DW-1:1];
  assign quo_o   = quo_q[NS-1];
  assign ovf_o   = ovf_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

FILE: hdl/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Width        Content
// s_axis   in   tdata 144    m00 m01 m02 m10 m11 m12 m20 m21 m22, 16b each
// m_axis   out  tdata 64     qw qx qy qz, 16b each
//                tuser 2     branch_taken
//
// One matrix per cycle in and one quaternion per cycle out when not stalled.
// The pipeline is one front stage, one square-root stage per result bit,
// 18 divider stages and one output register. Each stage holds its own
// valid bit and fills in bubbles, so the input is taken while a finished
// result waits if a later stage is empty. Reset clears only the valid bits.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [MatW-1:0]   s_axis_tdata,   // m00..m22, m00 at the lowest bits
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [4*ElemW-1:0] m_axis_tdata,  // qw, qx, qy, qz from the lowest bits
  output logic [1:0]        m_axis_tuser    // branch_taken
);

  localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int NW  = RW + FRAC_BITS;
  localparam int SW  = (NW + 1) / 2;
  localparam int SQW = 2 + NumLanes + NumLanes * MagW;
  localparam int DVW = 2 + NumLanes;

  // front stage
  logic                          fr_v, fr_rdy;
  logic [RW-1:0]                 fr_rad;
  branch_e                       fr_br;
  logic [NumLanes-1:0]           fr_neg;
  logic [NumLanes-1:0][MagW-1:0] fr_mag;

  // square root
  logic                          sq_v, sq_rdy;
  logic [SW-1:0]                 sq_s;
  logic [SQW-1:0]                sq_side;
  logic [NumLanes-1:0][MagW-1:0] sq_mag;

  // divider
  logic                          dv_v, dv_rdy;
  logic [SW-1:0]                 dv_s;
  logic [NumLanes-1:0][QuoW-1:0] dv_quo;
  logic [NumLanes-1:0]           dv_ovf;
  logic [DVW-1:0]                dv_side;
  logic [NumLanes-1:0]           dv_neg;
  branch_e                       dv_br;

  // output stage
  logic                          out_v_q, out_adv;
  logic [4*ElemW-1:0]            q_q, q_d;
  logic [1:0]                    br_q;
  logic [SW:0]                   main_sum;
  logic [SW+15:0]                main_x;
  logic [ElemW-1:0]              main_c;
  logic [ElemW-1:0]              lane_c [NumLanes];

  rmq_front #(
    .FRAC_BITS (FRAC_BITS),
    .RW        (RW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .mat_i   (s_axis_tdata),
    .valid_o (fr_v),
    .ready_i (fr_rdy),
    .rad_o   (fr_rad),
    .br_o    (fr_br),
    .neg_o   (fr_neg),
    .mag_o   (fr_mag)
  );

  rmq_sqrt #(
    .NW     (NW),
    .SW     (SW),
    .SIDE_W (SQW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_v),
    .ready_o (fr_rdy),
    .n_i     ({fr_rad, {FRAC_BITS{1'b0}}}),
    .side_i  ({fr_mag, fr_neg, fr_br}),
    .valid_o (sq_v),
    .ready_i (sq_rdy),
    .s_o     (sq_s),
    .side_o  (sq_side)
  );

  assign sq_mag = sq_side[SQW-1:DVW];

  rmq_div #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW),
    .SIDE_W    (DVW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .ready_o (sq_rdy),
    .s_i     (sq_s),
    .mag_i   (sq_mag),
    .side_i  (sq_side[DVW-1:0]),
    .valid_o (dv_v),
    .ready_i (dv_rdy),
    .s_o     (dv_s),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  assign dv_br  = branch_e'(dv_side[1:0]);
  assign dv_neg = dv_side[DVW-1:2];

  // Main component, signed saturation of lanes, placement by branch
  always_comb begin
    main_sum = {1'b0, dv_s} + (SW+1)'(1);
    main_x   = {16'b0, main_sum[SW:1]};
    main_c   = (main_x > (SW+16)'(32767)) ? 16'h7FFF : main_x[15:0];
    for (int l = 0; l < NumLanes; l++) begin
      if (dv_neg[l]) begin
        lane_c[l] = (dv_ovf[l] || dv_quo[l] > 16'd32768) ? 16'h8000 : 16'(-dv_quo[l]);
      end else begin
        lane_c[l] = (dv_ovf[l] || dv_quo[l] > 16'd32767) ? 16'h7FFF : dv_quo[l];
      end
    end
    case (dv_br)
      BR_TRACE: q_d = {lane_c[2], lane_c[1], lane_c[0], main_c};
      BR_X:     q_d = {lane_c[2], lane_c[1], main_c, lane_c[0]};
      BR_Y:     q_d = {lane_c[2], main_c, lane_c[1], lane_c[0]};
      default:  q_d = {main_c, lane_c[2], lane_c[1], lane_c[0]};
    endcase
  end

  assign out_adv = !out_v_q || m_axis_tready;
  assign dv_rdy  = out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && dv_v) begin
      q_q  <= q_d;
      br_q <= dv_br;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = q_q;
  assign m_axis_tuser  = br_q;

endmodule

FILE: sim/rotation_matrix_to_quaternion_top_tb.sv
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top_tb import rmq_pkg::*;;

  localparam int FracBits   = 14;
  localparam int LatencyCyc = 40;
  localparam longint CycleLimit = 400000;
  localparam int NumRandom  = 1100;

  typedef logic signed [ElemW-1:0] elem_t;

  typedef struct packed {
    elem_t   qw;
    elem_t   qx;
    elem_t   qy;
    elem_t   qz;
    branch_e br;
  } quat_t;

  // One directed row: matrix, plus an optional typed-in result
  typedef struct {
    elem_t m[9];
    bit    fixed;
    quat_t q;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [MatW-1:0]    s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [4*ElemW-1:0] m_axis_tdata;
  logic [1:0]         m_axis_tuser;

  quat_t  quat_q[$];
  int     mismatches;
  longint cycles;
  int     send_idle_pct;
  int     recv_idle_pct;

  rotation_matrix_to_quaternion_top #(.FRAC_BITS(FracBits)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // m00 m01 m02 m10 m11 m12 m20 m21 m22
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // qw qx qy qz
    .m_axis_tuser (m_axis_tuser)    // branch_taken
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic elem_t clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return elem_t'(v);
  endfunction

  // d * 0.5 / s, rounded half away from zero, saturated
  function automatic elem_t half_over_root(longint d, longint unsigned s);
    longint unsigned mag;
    longint unsigned quo;
    mag = (d < 0) ? longint'(-d) : d;
    quo = ((mag << FracBits) + s) / (2 * s);
    if (quo > 64'h7fff_ffff) quo = 64'h7fff_ffff;
    return clip16((d < 0) ? -longint'(quo) : longint'(quo));
  endfunction

  function automatic quat_t matrix_to_quat(elem_t m[9]);
    longint a[9];
    longint tr;
    longint rad;
    longint dw;
    longint dx;
    longint dy;
    longint dz;
    longint unsigned s;
    elem_t  mainc;
    quat_t  q;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    dw = 0; dx = 0; dy = 0; dz = 0;
    tr = a[0] + a[4] + a[8];
    if (tr >= 0) q.br = BR_TRACE;
    else if (a[4] > a[0]) q.br = (a[8] > a[4]) ? BR_Z : BR_Y;
    else q.br = (a[8] > a[0]) ? BR_Z : BR_X;
    case (q.br)
      BR_TRACE: begin
        rad = tr + (64'sd1 << FracBits);
        dx = a[7] - a[5]; dy = a[2] - a[6]; dz = a[3] - a[1];
      end
      BR_X: begin
        rad = a[0] - (a[4] + a[8]) + (64'sd1 << FracBits);
        dy = a[1] + a[3]; dz = a[6] + a[2]; dw = a[7] - a[5];
      end
      BR_Y: begin
        rad = a[4] - (a[8] + a[0]) + (64'sd1 << FracBits);
        dz = a[5] + a[7]; dx = a[1] + a[3]; dw = a[2] - a[6];
      end
      default: begin
        rad = a[8] - (a[0] + a[4]) + (64'sd1 << FracBits);
        dx = a[6] + a[2]; dy = a[5] + a[7]; dw = a[3] - a[1];
      end
    endcase
    if (rad < 1) rad = 1;
    s = int_sqrt(longint'(rad) << FracBits);
    if (s == 0) s = 1;
    mainc = clip16(longint'((s + 1) >> 1));
    q.qw = (q.br == BR_TRACE) ? mainc : half_over_root(dw, s);
    q.qx = (q.br == BR_X) ? mainc : half_over_root(dx, s);
    q.qy = (q.br == BR_Y) ? mainc : half_over_root(dy, s);
    q.qz = (q.br == BR_Z) ? mainc : half_over_root(dz, s);
    return q;
  endfunction

  // Drive one matrix and wait for its transaction
  task automatic send_matrix(elem_t m[9], quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    for (int i = 0; i < 9; i++) s_axis_tdata[i*ElemW +: ElemW] <= m[i];
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    quat_q.push_back(q);
  endtask

  // Receiver stalls and result check
  always @(posedge clk_i) begin
    quat_t got;
    quat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.qw = m_axis_tdata[0 +: ElemW];
        got.qx = m_axis_tdata[ElemW +: ElemW];
        got.qy = m_axis_tdata[2*ElemW +: ElemW];
        got.qz = m_axis_tdata[3*ElemW +: ElemW];
        got.br = branch_e'(m_axis_tuser);
        if (quat_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = quat_q.pop_front();
          if (got.qw !== want.qw || got.qx !== want.qx || got.qy !== want.qy ||
              got.qz !== want.qz || got.br !== want.br) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Random matrix: half bounded to +/-1.0 of random sign, some raw noise or extremes
  function automatic void rand_matrix(output elem_t m[9]);
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 3) m[i] = elem_t'($urandom);
      else if (mode < 8) m[i] = elem_t'($urandom_range(32768) - 16384);
      else m[i] = elem_t'($urandom_range(1) ? 16'sh7fff : 16'sh8000);
    end
    // bias the diagonal so every branch comes up often
    if (mode >= 3 && mode < 8) begin
      m[4*$urandom_range(2)] = elem_t'($urandom_range(16384, 4096));
      if ($urandom_range(1)) m[0] = -m[0];
    end
  endfunction

  task automatic run_random(int n, int sp, int rp);
    elem_t m[9];
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int k = 0; k < n; k++) begin
      rand_matrix(m);
      send_matrix(m, matrix_to_quat(m));
    end
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    elem_t e[9];
    quat_t q;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    cycles        = 0;
    mismatches    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    // identity: w = 1.0, rest zero
    r.m = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
    r.fixed = 1; r.q = '{16'sd16384, 0, 0, 0, BR_TRACE};
    rows.push_back(r);
    // all zero: trace zero, w = 0.5
    r.m = '{default: 0};
    r.fixed = 1; r.q = '{16'sd8192, 0, 0, 0, BR_TRACE};
    rows.push_back(r);
    r.fixed = 0;
    // 180 deg about x, y, z
    r.m = '{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384}; rows.push_back(r);
    r.m = '{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384}; rows.push_back(r);
    r.m = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384}; rows.push_back(r);
    // diagonal ties
    r.m = '{-16'sd100, 5, 6, 7, -16'sd100, 8, 9, 10, -16'sd100}; rows.push_back(r);
    r.m = '{-16'sd300, 5, 6, 7, -16'sd100, 8, 9, 10, -16'sd100}; rows.push_back(r);
    r.m = '{-16'sd100, 5, 6, 7, -16'sd300, 8, 9, 10, -16'sd100}; rows.push_back(r);
    // most negative diagonal
    r.m = '{-16'sh8000, 0, 0, 0, -16'sh8000, 0, 0, 0, -16'sh8000}; rows.push_back(r);
    r.m = '{-16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
            -16'sh8000, 16'sh7fff, -16'sh8000}; rows.push_back(r);
    // saturation extremes
    r.m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
            16'sh7fff, 16'sh7fff, 16'sh7fff}; rows.push_back(r);
    r.m = '{16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000,
            -16'sh8000, 16'sh7fff, 16'sh7fff}; rows.push_back(r);
    r.m = '{16'sh0, -16'sh8000, 16'sh7fff, 16'sh7fff, -16'sd1, -16'sh8000,
            -16'sh8000, 16'sh7fff, 16'sh0}; rows.push_back(r);
    r.m = '{16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
            16'shffff, 16'shffff, 16'shffff}; rows.push_back(r);
    // 90 deg about z
    r.m = '{0, -16'sd16384, 0, 16'sd16384, 0, 0, 0, 0, 16'sd16384}; rows.push_back(r);

    foreach (rows[i]) begin
      e = rows[i].m;
      q = rows[i].fixed ? rows[i].q : matrix_to_quat(e);
      send_matrix(e, q);
    end

    run_random(NumRandom / 3, 22, 51);
    run_random(NumRandom / 3, 51, 22);
    run_random(NumRandom / 3, 0, 0);
    s_axis_tvalid <= 1'b0;

    // Drain
    while (quat_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LatencyCyc) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
